// ----- src/sed_pkg.sv -----
package sed_pkg;

  localparam int ByteW  = 8;
  localparam int QDepth = 3;
  localparam int CntW   = $clog2(QDepth + 1);

  typedef enum logic [1:0] {
    WARN_NONE     = 2'd0,
    WARN_OVERFLOW = 2'd1,
    WARN_UNKNOWN  = 2'd2
  } warn_t;

  typedef struct packed {
    logic [ByteW-1:0] out_byte;
    logic             has_byte;
    warn_t            warn_code;
    logic             end_of_string;
  } result_t;

  localparam logic [ByteW-1:0] CH_BSLASH  = 8'h5C;
  localparam logic [ByteW-1:0] CH_SQUOTE  = 8'h27;
  localparam logic [ByteW-1:0] CH_DQUOTE  = 8'h22;
  localparam logic [ByteW-1:0] CH_NEWLINE = 8'h0A;
  localparam logic [ByteW-1:0] CH_LBRACE  = 8'h7B;
  localparam logic [ByteW-1:0] CH_LOW_A   = 8'h61;
  localparam logic [ByteW-1:0] CH_LOW_B   = 8'h62;
  localparam logic [ByteW-1:0] CH_LOW_F   = 8'h66;
  localparam logic [ByteW-1:0] CH_LOW_N   = 8'h6E;
  localparam logic [ByteW-1:0] CH_LOW_R   = 8'h72;
  localparam logic [ByteW-1:0] CH_LOW_T   = 8'h74;
  localparam logic [ByteW-1:0] CH_LOW_V   = 8'h76;
  localparam logic [ByteW-1:0] CH_LOW_X   = 8'h78;

  localparam logic [ByteW-1:0] CTL_BEL = 8'h07;
  localparam logic [ByteW-1:0] CTL_BS  = 8'h08;
  localparam logic [ByteW-1:0] CTL_FF  = 8'h0C;
  localparam logic [ByteW-1:0] CTL_LF  = 8'h0A;
  localparam logic [ByteW-1:0] CTL_CR  = 8'h0D;
  localparam logic [ByteW-1:0] CTL_HT  = 8'h09;
  localparam logic [ByteW-1:0] CTL_VT  = 8'h0B;

endpackage

// ----- src/sed_if.sv -----
interface sed_in_if;
  import sed_pkg::*;

  logic             valid;
  logic             ready;
  logic [ByteW-1:0] in_byte;
  logic             final_byte;

  modport source (output valid, in_byte, final_byte, input ready);
  modport sink   (input valid, in_byte, final_byte, output ready);
endinterface

interface sed_out_if;
  import sed_pkg::*;

  logic             valid;
  logic             ready;
  logic [ByteW-1:0] out_byte;
  logic             has_byte;
  warn_t            warn_code;
  logic             end_of_string;

  modport source (output valid, out_byte, has_byte, warn_code, end_of_string, input ready);
  modport sink   (input valid, out_byte, has_byte, warn_code, end_of_string, output ready);
endinterface

// ----- src/string_escape_decoder_top.sv -----
// String literal escape decoder.
// in_ch takes one raw byte of a string body per request, with final_byte set
// on its last byte. out_ch gives decoded bytes; has_byte is low for an end
// marker or a dropped unknown escape, warn_code flags numeric overflow or an
// unknown escape, and end_of_string marks the last result of the final byte.
// One input byte gives zero, one or two results.
// A result is registered into the result queue when its input is taken.
// Throughput: one input byte per cycle while in_ch.ready is high. Each byte is
// decoded combinationally from the decoder state into a three-entry result
// queue; in_ch.ready is high while at most one result is waiting, so a byte
// that makes two results holds input until one of them has left the queue,
// even while the receiver drains. When out_ch stalls, results hold in the
// queue and input stops once two are pending.
// Reset (synchronous, rst_n low) empties the queue and returns the decoder
// to plain mode with a cleared accumulator and overflow flag. The state is
// also cleared after every final byte.
module string_escape_decoder_top (
  input  logic              clk,
  input  logic              rst_n,
  sed_in_if.sink            in_ch,
  sed_out_if.source         out_ch
);
  import sed_pkg::*;

  typedef enum logic [1:0] {
    MODE_PLAIN = 2'd0,
    MODE_ESC   = 2'd1,
    MODE_OCT   = 2'd2,
    MODE_HEX   = 2'd3
  } mode_t;

  mode_t            mode_r, mode_nxt;
  logic [ByteW-1:0] acc_r, acc_nxt;
  logic             ovf_r, ovf_nxt;

  result_t          q_r [QDepth];
  result_t          q_nxt [QDepth];
  logic [CntW-1:0]  cnt_r, cnt_nxt;

  result_t          res [2];
  logic [1:0]       n_res;
  logic             taken;
  logic [ByteW-1:0] c;
  logic             is_oct;
  logic             is_hex;
  logic [3:0]       hex_d;
  logic [ByteW-1:0] esc_v;
  logic             esc_simple;

  logic             push;
  logic             pop;
  logic [CntW-1:0]  base;

  assign c = in_ch.in_byte;

  assign is_oct = (c >= 8'h30) && (c <= 8'h37);

  always_comb begin
    is_hex = 1'b1;
    hex_d  = c[3:0];
    if ((c >= 8'h30) && (c <= 8'h39)) begin
      hex_d = c[3:0];
    end else if (((c >= 8'h61) && (c <= 8'h66)) || ((c >= 8'h41) && (c <= 8'h46))) begin
      hex_d = c[3:0] + 4'd9;
    end else begin
      is_hex = 1'b0;
    end
  end

  always_comb begin
    esc_simple = 1'b1;
    esc_v      = c;
    unique case (c)
      CH_LOW_A:   esc_v = CTL_BEL;
      CH_LOW_B:   esc_v = CTL_BS;
      CH_LOW_F:   esc_v = CTL_FF;
      CH_LOW_N:   esc_v = CTL_LF;
      CH_LOW_R:   esc_v = CTL_CR;
      CH_LOW_T:   esc_v = CTL_HT;
      CH_LOW_V:   esc_v = CTL_VT;
      CH_BSLASH:  esc_v = CH_BSLASH;
      CH_SQUOTE:  esc_v = CH_SQUOTE;
      CH_DQUOTE:  esc_v = CH_DQUOTE;
      default:    esc_simple = 1'b0;
    endcase
  end

  always_comb begin
    mode_nxt = mode_r;
    acc_nxt  = acc_r;
    ovf_nxt  = ovf_r;
    taken    = 1'b0;
    n_res    = 2'd0;
    res[0]   = '{out_byte: '0, has_byte: 1'b0, warn_code: WARN_NONE, end_of_string: 1'b0};
    res[1]   = res[0];

    if (mode_r == MODE_OCT || mode_r == MODE_HEX) begin
      if (mode_r == MODE_OCT && is_oct) begin
        ovf_nxt = ovf_r | (acc_r >= 8'd32);
        acc_nxt = {acc_r[4:0], c[2:0]};
        taken   = 1'b1;
      end else if (mode_r == MODE_HEX && is_hex) begin
        ovf_nxt = ovf_r | (acc_r >= 8'd16);
        acc_nxt = {acc_r[3:0], hex_d};
        taken   = 1'b1;
      end else begin
        res[0].out_byte  = acc_r;
        res[0].has_byte  = 1'b1;
        res[0].warn_code = ovf_r ? WARN_OVERFLOW : WARN_NONE;
        n_res    = 2'd1;
        mode_nxt = MODE_PLAIN;
        acc_nxt  = '0;
        ovf_nxt  = 1'b0;
      end
    end

    if (!taken) begin
      if (mode_nxt == MODE_ESC) begin
        mode_nxt = MODE_PLAIN;
        if (esc_simple) begin
          res[0].out_byte = esc_v;
          res[0].has_byte = 1'b1;
          n_res = 2'd1;
        end else if (c == CH_NEWLINE) begin
          n_res = 2'd0;
        end else if (c == CH_LBRACE) begin
          res[0].out_byte = CH_BSLASH;
          res[0].has_byte = 1'b1;
          res[1].out_byte = CH_LBRACE;
          res[1].has_byte = 1'b1;
          n_res = 2'd2;
        end else if (c == CH_LOW_X) begin
          mode_nxt = MODE_HEX;
          acc_nxt  = '0;
          ovf_nxt  = 1'b0;
        end else if (is_oct) begin
          mode_nxt = MODE_OCT;
          acc_nxt  = {5'd0, c[2:0]};
          ovf_nxt  = 1'b0;
        end else begin
          res[0].warn_code = WARN_UNKNOWN;
          n_res = 2'd1;
        end
      end else if (c == CH_BSLASH) begin
        mode_nxt = MODE_ESC;
      end else begin
        res[n_res[0]].out_byte = c;
        res[n_res[0]].has_byte = 1'b1;
        n_res = n_res + 2'd1;
      end
    end

    if (in_ch.final_byte) begin
      if (n_res < 2'd2) begin
        if (mode_nxt == MODE_OCT || mode_nxt == MODE_HEX) begin
          res[n_res[0]].out_byte  = acc_nxt;
          res[n_res[0]].has_byte  = 1'b1;
          res[n_res[0]].warn_code = ovf_nxt ? WARN_OVERFLOW : WARN_NONE;
          n_res = n_res + 2'd1;
        end else if (mode_nxt == MODE_ESC) begin
          res[n_res[0]].warn_code = WARN_UNKNOWN;
          n_res = n_res + 2'd1;
        end
      end
      if (n_res == 2'd0) begin
        n_res = 2'd1;
      end
      res[n_res[1]].end_of_string = 1'b1;
      mode_nxt = MODE_PLAIN;
      acc_nxt  = '0;
      ovf_nxt  = 1'b0;
    end
  end

  assign in_ch.ready  = (cnt_r <= CntW'(1));
  assign push         = in_ch.valid && in_ch.ready;
  assign out_ch.valid = (cnt_r != '0);
  assign pop          = out_ch.valid && out_ch.ready;
  assign base         = cnt_r - CntW'(pop);

  assign out_ch.out_byte      = q_r[0].out_byte;
  assign out_ch.has_byte      = q_r[0].has_byte;
  assign out_ch.warn_code     = q_r[0].warn_code;
  assign out_ch.end_of_string = q_r[0].end_of_string;

  always_comb begin
    for (int i = 0; i < QDepth; i++) begin
      if (pop && i < QDepth - 1) begin
        q_nxt[i] = q_r[i + 1];
      end else begin
        q_nxt[i] = q_r[i];
      end
      if (push && (CntW'(i) == base) && (n_res != 2'd0)) begin
        q_nxt[i] = res[0];
      end
      if (push && (CntW'(i) == base + CntW'(1)) && (n_res == 2'd2)) begin
        q_nxt[i] = res[1];
      end
    end
    cnt_nxt = base + (push ? CntW'(n_res) : '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      mode_r <= MODE_PLAIN;
      acc_r  <= '0;
      ovf_r  <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) begin
        mode_r <= mode_nxt;
        acc_r  <= acc_nxt;
        ovf_r  <= ovf_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < QDepth; i++) begin
      q_r[i] <= q_nxt[i];
    end
  end

endmodule
